// File: sv/dpmf_pkg.sv
// Shared package of the defective pixel mean fill core.
// Holds the default sizes, the register indexes, the sequencer states and the
// command and status structs between controller and datapath.
package dpmf_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_PIXEL_BITS  = 16;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_POS_W   = 10;

    localparam int RESET_COLUMNS = 640;
    localparam int RESET_ROWS    = 480;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 1'b1;

    // Input op codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic eval;
        logic div;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic replace;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: sv/dpmf_if.sv
// Valid/ready channel interfaces of the defective pixel mean fill core.
// Depends on nothing; the pixel width is a parameter.
interface dpmf_in_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface dpmf_out_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic [9:0]                   out_row;
    logic [9:0]                   out_column;
    logic                         was_replaced;
    logic                         frame_end;

    modport source (output valid, output pixel_out, output out_row, output out_column,
                    output was_replaced, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_column,
                    input was_replaced, input frame_end, output ready);
endinterface

// File: sv/dpmf_ctrl.sv
// Sequencer of the defective pixel mean fill core.
// Depends on dpmf_pkg for the state type and the command and status structs.
module dpmf_ctrl
    import dpmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_sts.drop) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: n_state = ST_EVAL;
            ST_EVAL: begin
                if (!i_sts.emit) begin
                    n_state = ST_IDLE;
                end else if (i_sts.replace) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_STEP: o_cmd.step = 1'b1;
            ST_EVAL: o_cmd.eval = i_sts.emit;
            ST_DIV:  o_cmd.div  = 1'b1;
            ST_FIN:  o_cmd.fin  = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: sv/dpmf_datapath.sv
// Datapath of the defective pixel mean fill core: line stores, 3x3 window,
// position counters, neighbor sum, bit-serial divider and output register.
// Depends on dpmf_pkg and the channel interfaces.
module dpmf_datapath
    import dpmf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    dpmf_in_if.sink                i_pix,
    dpmf_out_if.source             o_pix,
    input  t_cmd                   i_cmd,
    output t_status                o_sts
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int SW = PIXEL_BITS + 2;
    localparam int IW = $clog2(SW);

    logic [CW-1:0] r_cols;
    logic [RW-1:0] r_rows;
    logic [CW-1:0] r_in_col;
    logic [RW:0]   r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    logic [PIXEL_BITS-1:0] r_line_prev  [MAX_COLUMNS];
    logic [PIXEL_BITS-1:0] r_line_older [MAX_COLUMNS];
    logic [PIXEL_BITS-1:0] r_rd_top;
    logic [PIXEL_BITS-1:0] r_rd_mid;
    logic [PIXEL_BITS-1:0] r_pix;
    logic                  r_phase;
    logic [CW-1:0]         r_col;
    logic [PIXEL_BITS-1:0] r_win [9];
    logic                  r_emit;

    logic [SW-1:0]         r_quot;
    logic [4:0]            r_rem;
    logic [3:0]            r_div;
    logic [IW-1:0]         r_iter;
    logic                  r_rep;
    logic [PIXEL_BITS-1:0] r_center;

    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic [OUT_POS_W-1:0]  r_out_row_q;
    logic [OUT_POS_W-1:0]  r_out_col_q;
    logic                  r_out_rep;
    logic                  r_out_last;

    logic [CW-1:0]         eff_col;
    logic                  phase;
    logic [SW-1:0]         sum;
    logic [3:0]            cnt;
    logic                  interior;
    logic                  last;
    logic [5:0]            rem_sh;
    logic [4:0]            rem_sub;
    logic [CW-1:0]         n_cols;
    logic [RW-1:0]         n_rows;

    assign eff_col = (r_in_col >= r_cols) ? '0 : r_in_col;
    assign phase   = ({1'b0, r_rows} > r_in_row);

    // Configuration writes clamp into 1..max.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cols = CW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_COLUMNS)) begin
            n_cols = CW'(MAX_COLUMNS);
        end else begin
            n_cols = CW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            n_rows = RW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
            n_rows = RW'(MAX_ROWS);
        end else begin
            n_rows = RW'(i_cfg_data);
        end
    end

    // Neighbor sum and count over the non-negative ones of the eight non-center taps.
    always_comb begin
        sum = '0;
        cnt = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && !r_win[k][PIXEL_BITS-1]) begin
                sum = sum + SW'(r_win[k]);
                cnt = cnt + 4'd1;
            end
        end
    end

    assign interior = r_win[4][PIXEL_BITS-1] && (r_out_row != '0)
                      && ((32'(r_out_row) + 2) <= 32'(r_rows))
                      && (r_out_col != '0)
                      && ((32'(r_out_col) + 2) <= 32'(r_cols));

    assign last = (32'(r_out_row) + 1 == 32'(r_rows))
                  && (32'(r_out_col) + 1 == 32'(r_cols));

    assign rem_sh  = {r_rem, r_quot[SW-1]};
    assign rem_sub = 5'(rem_sh - {2'b00, r_div});

    assign o_sts.drop     = phase && (i_pix.op == OP_DRAIN);
    assign o_sts.emit     = r_emit;
    assign o_sts.replace  = interior;
    assign o_sts.div_done = (r_iter == IW'(SW - 1));
    assign o_sts.out_free = !r_out_valid || o_pix.ready;

    // Line stores: read on accept, written during the step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_top <= r_line_older[eff_col[AW-1:0]];
            r_rd_mid <= r_line_prev[eff_col[AW-1:0]];
        end
        if (i_cmd.step && r_phase) begin
            r_line_older[r_col[AW-1:0]] <= r_rd_mid;
            r_line_prev[r_col[AW-1:0]]  <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= CW'(RESET_COLUMNS);
            r_rows      <= RW'(RESET_ROWS);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_COLUMNS) begin
                    r_cols <= n_cols;
                end else begin
                    r_rows <= n_rows;
                end
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
            if (i_cmd.accept) begin
                r_pix   <= i_pix.pixel_in;
                r_phase <= phase;
                r_col   <= eff_col;
            end
            if (i_cmd.step) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= r_rd_top;
                r_win[5] <= r_rd_mid;
                r_win[8] <= r_phase ? r_pix : '0;
                r_emit   <= (r_in_row >= (RW+1)'(2))
                            || (r_in_row == (RW+1)'(1) && r_col != '0);
                if (32'(r_col) + 1 >= 32'(r_cols)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_col + 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fin) begin
                if (last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (32'(r_out_col) + 1 == 32'(r_cols)) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // Mean divider, one quotient bit per cycle; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_rep    <= interior;
            r_center <= r_win[4];
            r_rem    <= '0;
            r_iter   <= '0;
            r_quot   <= (cnt == '0) ? '0 : sum;
            r_div    <= (cnt == '0) ? 4'd1 : cnt;
        end
        if (i_cmd.div) begin
            r_iter <= r_iter + 1'b1;
            if (rem_sh >= {2'b00, r_div}) begin
                r_rem  <= rem_sub;
                r_quot <= {r_quot[SW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[4:0];
                r_quot <= {r_quot[SW-2:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            r_out_pix   <= r_rep ? r_quot[PIXEL_BITS-1:0] : r_center;
            r_out_row_q <= OUT_POS_W'(r_out_row);
            r_out_col_q <= OUT_POS_W'(r_out_col);
            r_out_rep   <= r_rep;
            r_out_last  <= last;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_out    = r_out_pix;
    assign o_pix.out_row      = r_out_row_q;
    assign o_pix.out_column   = r_out_col_q;
    assign o_pix.was_replaced = r_out_rep;
    assign o_pix.frame_end    = r_out_last;

endmodule

// File: sv/defective_pixel_mean_fill_core.sv
// Top level of the defective pixel mean fill core.
// Depends on dpmf_pkg, the channel interfaces, dpmf_ctrl and dpmf_datapath.
//
// The core takes one word per handshake on i_pix, in raster order, and gives
// corrected pixels on o_pix, one row plus one pixel behind the input. A negative
// pixel is defective; an interior defective pixel is replaced by the truncated
// mean of its non-negative 3x3 neighbors from the uncorrected image (0 when none
// is usable), while border and good pixels pass as they are. Once a frame's
// pixels are all in, every input word acts as a drain tick that pushes out the
// next pending result; a drain word before that is consumed with no effect.
// The block works on one word at a time under a small sequencer. A drain word
// ignored mid-frame is only accepted. Any other word passes accept, line store
// read and window shift, and evaluation; when it yields a result, the bit-serial
// divider forms PIXEL_BITS+2 quotient bits (18 at 16 bits) if a defective pixel
// is replaced, and the output register is loaded once free. The output register
// lets the next word in while a result waits downstream. Writes to
// columns_in_use (index 0) or rows_in_use (index 1) are clamped into
// 1..maximum and restart the frame; write them only while the core is idle.
module defective_pixel_mean_fill_core
    import dpmf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    dpmf_in_if.sink                i_pix,
    dpmf_out_if.source             o_pix
);

    t_cmd    cmd;
    t_status sts;

    // The sequencer owns the input ready; the datapath owns everything else.
    dpmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dpmf_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_pix       (o_pix),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

`ifndef SYNTH
    // The sequencer issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.step, cmd.eval, cmd.div, cmd.fin}))
        else $error("more than one datapath command in a cycle");

    // A word that is not dropped is always followed by the window step.
    a_step_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && i_pix.valid && !sts.drop) |=> cmd.step)
        else $error("accepted word was not stepped");

    // No new word is taken while the divider runs.
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div |-> !i_pix.ready)
        else $error("input ready during division");
`endif

endmodule
